@@ rtl/core/cte_pkg.sv @@
package cte_pkg;

    // Field widths
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned OFFH_W   = 5;
    localparam int unsigned OFFM_W   = 6;
    localparam int unsigned EPOCH_W  = 39;

    // Internal widths
    localparam int unsigned TOD_W  = 19;   // time of day less offset, signed
    localparam int unsigned ERAQ_W = 6;    // era index for non-negative years
    localparam int unsigned ERA_W  = 7;    // signed era
    localparam int unsigned YOE_W  = 9;    // year of era
    localparam int unsigned DOY_W  = 10;   // signed day of year
    localparam int unsigned DOE_W  = 19;   // signed day of era
    localparam int unsigned DAYS_W = 24;   // signed day number
    localparam int unsigned PROD_W = 41;   // signed day number in seconds
    localparam int unsigned SUM_W  = 42;

    // Calendar constants
    localparam int unsigned ERA_RECIP     = 5243;  // ceil(2^21 / 400)
    localparam int unsigned ERA_SHIFT     = 21;
    localparam int unsigned YEARS_PER_ERA = 400;
    localparam int unsigned LAST_YOE      = 399;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned DAYS_PER_ERA  = 146097;
    localparam int unsigned EPOCH_DAYS    = 719468;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;

    // Saturation limits of the result
    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(64'sd274877906943);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(64'sd274877906944);

    // Input transaction
    typedef struct packed {
        logic [OFFM_W-1:0]   offset_minutes;
        logic [OFFH_W-1:0]   offset_hours;
        logic                offset_negative;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } stamp_t;

    // After year shift and era estimate
    typedef struct packed {
        logic [YEAR_W-1:0]       y;
        logic                    y_neg;
        logic [ERAQ_W-1:0]       era_q;
        logic [MONTH_W-1:0]      mp;
        logic [DAY_W-1:0]        day;
        logic signed [TOD_W-1:0] tod;
    } split_t;

    // Era, year of era, day of year
    typedef struct packed {
        logic signed [ERA_W-1:0] era;
        logic [YOE_W-1:0]        yoe;
        logic signed [DOY_W-1:0] doy;
        logic signed [TOD_W-1:0] tod;
    } year_t;

    typedef struct packed {
        logic signed [ERA_W-1:0] era;
        logic signed [DOE_W-1:0] doe;
        logic signed [TOD_W-1:0] tod;
    } doe_t;

    typedef struct packed {
        logic signed [DAYS_W-1:0] days;
        logic signed [TOD_W-1:0]  tod;
    } dnum_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic signed [TOD_W-1:0]  tod;
    } prod_t;

    // Days before the start of a March-based month: (153*mp+2)/5
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Centuries within an era (yoe / 100, yoe below 400)
    function automatic logic [1:0] centuries(input logic [YOE_W-1:0] yoe);
        logic [1:0] r;
        priority if (yoe >= YOE_W'(300)) r = 2'd3;
        else if (yoe >= YOE_W'(200))     r = 2'd2;
        else if (yoe >= YOE_W'(100))     r = 2'd1;
        else                             r = 2'd0;
        return r;
    endfunction

endpackage

@@ rtl/core/civil_time_to_epoch_seconds_unit.sv @@
// Channel   Dir   Ports                          Payload
// s_        in    s_tvalid s_tready s_tdata[55:0] civil timestamp and zone offset
// m_        out   m_tvalid m_tready m_tdata[39:0] signed seconds since epoch, UTC
//
// Six register stages: year split, era/day of year, day of era, day number,
// seconds product, sum with clamp. One transaction per cycle while m_ accepts.
// Each stage holds its own valid bit; a stage advances when the next has room,
// so bubbles close up and a stall at m_ loses and repeats nothing.
// aresetn (synchronous) clears the valid bits only.
module civil_time_to_epoch_seconds_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28]
    // second[39:34] offset_negative[40] offset_hours[45:41]
    // offset_minutes[51:46], zeros above
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // epoch_seconds[38:0] signed, zero at bit 39
    output logic [39:0] m_tdata
);
    import cte_pkg::*;

    stamp_t stamp;
    year_t  yr_data;
    logic   yr_valid;
    logic   yr_ready;
    dnum_t  dn_data;
    logic   dn_valid;
    logic   dn_ready;
    logic signed [EPOCH_W-1:0] secs;

    assign stamp = stamp_t'(s_tdata[$bits(stamp_t)-1:0]);

    // Calendar year split, era, year of era and day of year
    cte_era u_era (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (stamp),
        .out_valid (yr_valid),
        .out_ready (yr_ready),
        .out_data  (yr_data)
    );

    // Day number
    cte_day u_day (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (yr_valid),
        .in_ready  (yr_ready),
        .in_data   (yr_data),
        .out_valid (dn_valid),
        .out_ready (dn_ready),
        .out_data  (dn_data)
    );

    // Seconds and output register
    cte_sec u_sec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dn_valid),
        .in_ready  (dn_ready),
        .in_data   (dn_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_secs  (secs)
    );

    assign m_tdata = {1'b0, secs};

endmodule

@@ rtl/core/cte_era.sv @@
module cte_era (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  cte_pkg::stamp_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output cte_pkg::year_t  out_data
);
    import cte_pkg::*;

    logic   a_vld_reg;
    logic   b_vld_reg;
    logic   adv_a;
    logic   adv_b;
    split_t a_reg;
    split_t a_next;
    year_t  b_reg;
    year_t  b_next;

    logic                    borrow;
    logic [YEAR_W:0]         y_ext;
    logic [YEAR_W+12:0]      era_prod;
    logic [17:0]             tod_pos;
    logic [16:0]             tod_off;

    // Stall chain: a stage moves when the one after it has room
    always_comb begin
        adv_b    = !b_vld_reg || out_ready;
        adv_a    = !a_vld_reg || adv_b;
        in_ready = adv_a;
    end

    // Stage A: March-based year, era estimate by reciprocal, time of day
    always_comb begin
        borrow   = (in_data.month <= MONTH_W'(2));
        y_ext    = {1'b0, in_data.year} - (YEAR_W+1)'(borrow);
        era_prod = (YEAR_W+13)'(y_ext[YEAR_W-1:0]) * (YEAR_W+13)'(ERA_RECIP);
        tod_pos  = 18'(in_data.hour) * 18'(SECS_PER_HOUR)
                 + 18'(in_data.minute) * 18'(SECS_PER_MIN)
                 + 18'(in_data.second);
        tod_off  = 17'(in_data.offset_hours) * 17'(SECS_PER_HOUR)
                 + 17'(in_data.offset_minutes) * 17'(SECS_PER_MIN);

        a_next.y     = y_ext[YEAR_W-1:0];
        a_next.y_neg = y_ext[YEAR_W];
        a_next.era_q = ERAQ_W'(era_prod >> ERA_SHIFT);
        a_next.mp    = borrow ? (in_data.month + MONTH_W'(9))
                              : (in_data.month - MONTH_W'(3));
        a_next.day   = in_data.day;
        // a minus zone is behind UTC, so its offset is added
        if (in_data.offset_negative) begin
            a_next.tod = $signed({1'b0, tod_pos}) + $signed({2'b0, tod_off});
        end else begin
            a_next.tod = $signed({1'b0, tod_pos}) - $signed({2'b0, tod_off});
        end
    end

    // Stage B: era, year of era and day of year
    always_comb begin
        if (a_reg.y_neg) begin
            b_next.era = -ERA_W'(1);
            b_next.yoe = YOE_W'(LAST_YOE);
        end else begin
            b_next.era = $signed({1'b0, a_reg.era_q});
            b_next.yoe = YOE_W'(a_reg.y - YEAR_W'(a_reg.era_q) * YEAR_W'(YEARS_PER_ERA));
        end
        b_next.doy = $signed({1'b0, month_start(a_reg.mp)})
                   + $signed({5'b0, a_reg.day}) - DOY_W'(1);
        b_next.tod = a_reg.tod;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (adv_a) a_vld_reg <= in_valid;
            if (adv_b) b_vld_reg <= a_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv_a && in_valid) a_reg <= a_next;
        if (adv_b && a_vld_reg) b_reg <= b_next;
    end

    assign out_valid = b_vld_reg;
    assign out_data  = b_reg;

endmodule

@@ rtl/core/cte_day.sv @@
module cte_day (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cte_pkg::year_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cte_pkg::dnum_t out_data
);
    import cte_pkg::*;

    logic  a_vld_reg;
    logic  b_vld_reg;
    logic  adv_a;
    logic  adv_b;
    doe_t  a_reg;
    doe_t  a_next;
    dnum_t b_reg;
    dnum_t b_next;

    logic [DOE_W-2:0] doe_base;

    always_comb begin
        adv_b    = !b_vld_reg || out_ready;
        adv_a    = !a_vld_reg || adv_b;
        in_ready = adv_a;
    end

    // Stage A: day of era with leap days
    always_comb begin
        doe_base = (DOE_W-1)'(in_data.yoe) * (DOE_W-1)'(DAYS_PER_YEAR)
                 + (DOE_W-1)'(in_data.yoe >> 2)
                 - (DOE_W-1)'(centuries(in_data.yoe));
        a_next.era = in_data.era;
        a_next.doe = $signed({1'b0, doe_base}) + DOE_W'(in_data.doy);
        a_next.tod = in_data.tod;
    end

    // Stage B: day number relative to the epoch
    always_comb begin
        b_next.days = DAYS_W'((DAYS_W+1)'(a_reg.era) * $signed((DAYS_W+1)'(DAYS_PER_ERA))
                    + (DAYS_W+1)'(a_reg.doe)
                    - $signed((DAYS_W+1)'(EPOCH_DAYS)));
        b_next.tod  = a_reg.tod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (adv_a) a_vld_reg <= in_valid;
            if (adv_b) b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a && in_valid) a_reg <= a_next;
        if (adv_b && a_vld_reg) b_reg <= b_next;
    end

    assign out_valid = b_vld_reg;
    assign out_data  = b_reg;

endmodule

@@ rtl/core/cte_sec.sv @@
module cte_sec (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cte_pkg::dnum_t                        in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cte_pkg::EPOCH_W-1:0]    out_secs
);
    import cte_pkg::*;

    logic  a_vld_reg;
    logic  b_vld_reg;
    logic  adv_a;
    logic  adv_b;
    prod_t a_reg;
    prod_t a_next;
    logic signed [EPOCH_W-1:0] b_reg;
    logic signed [EPOCH_W-1:0] b_next;

    logic signed [SUM_W-1:0] sum;

    always_comb begin
        adv_b    = !b_vld_reg || out_ready;
        adv_a    = !a_vld_reg || adv_b;
        in_ready = adv_a;
    end

    // Stage A: days to seconds
    always_comb begin
        a_next.prod = PROD_W'(in_data.days) * $signed(PROD_W'(SECS_PER_DAY));
        a_next.tod  = in_data.tod;
    end

    // Stage B: add time of day, clamp to the result range (output register)
    always_comb begin
        sum = SUM_W'(a_reg.prod) + SUM_W'(a_reg.tod);
        priority if (sum > OUT_MAX) b_next = EPOCH_W'(OUT_MAX);
        else if (sum < OUT_MIN)     b_next = EPOCH_W'(OUT_MIN);
        else                        b_next = EPOCH_W'(sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (adv_a) a_vld_reg <= in_valid;
            if (adv_b) b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a && in_valid) a_reg <= a_next;
        if (adv_b && a_vld_reg) b_reg <= b_next;
    end

    assign out_valid = b_vld_reg;
    assign out_secs  = b_reg;

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import cte_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28]
    // second[39:34] offset_negative[40] offset_hours[45:41]
    // offset_minutes[51:46], zeros above
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // epoch_seconds[38:0] signed, zero at bit 39
    logic [39:0] m_tdata;

    localparam int RANDOM_STAMPS = 1650;
    localparam int PHASE_LEN     = 110;
    localparam int MAX_GAP       = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 12;

    // Expected epoch seconds per accepted timestamp, checked in order
    class epoch_scoreboard;
        localparam longint DAYS_PER_ERA = 146097;
        localparam longint EPOCH_SHIFT  = 719468;
        localparam longint SECS_DAY     = 86400;
        localparam longint SECS_HOUR    = 3600;
        localparam longint SECS_MIN     = 60;
        localparam longint SECS_HI      = 64'sd274877906943;
        localparam longint SECS_LO      = -64'sd274877906944;

        logic [EPOCH_W-1:0] seconds_q[$];
        int unsigned        mismatches = 0;

        // Day number via March-based 400-year eras, then time of day less offset
        function logic [EPOCH_W-1:0] epoch_of(stamp_t st);
            longint y, m, d, era, yoe, mp, doy, doe, days, secs, offs;
            y = longint'(st.year);
            m = longint'(st.month);
            d = longint'(st.day);
            if (m <= 2) y = y - 1;
            era  = ((y >= 0) ? y : y - 399) / 400;
            yoe  = y - era * 400;
            mp   = (m > 2) ? m - 3 : m + 9;
            doy  = (153 * mp + 2) / 5 + d - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * DAYS_PER_ERA + doe - EPOCH_SHIFT;
            secs = days * SECS_DAY + longint'(st.hour) * SECS_HOUR
                   + longint'(st.minute) * SECS_MIN + longint'(st.second);
            offs = longint'(st.offset_hours) * SECS_HOUR
                   + longint'(st.offset_minutes) * SECS_MIN;
            secs = st.offset_negative ? secs + offs : secs - offs;
            // clamp to the signed 39-bit range
            if (secs > SECS_HI) secs = SECS_HI;
            if (secs < SECS_LO) secs = SECS_LO;
            return secs[EPOCH_W-1:0];
        endfunction

        function void note_stamp(stamp_t st);
            seconds_q.push_back(epoch_of(st));
        endfunction

        function void check_seconds(logic [EPOCH_W-1:0] got);
            logic [EPOCH_W-1:0] want;
            if (seconds_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d, nothing outstanding", $signed(got));
            end else begin
                want = seconds_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("epoch_seconds: expected %0d got %0d",
                                 $signed(want), $signed(got));
                end
            end
        endfunction

        function int pending();
            return seconds_q.size();
        endfunction
    endclass

    epoch_scoreboard sb = new();

    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    int idle_cycles = 0;

    civil_time_to_epoch_seconds_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitor both channels, watchdog on lack of progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_stamp(stamp_t'(s_tdata[$bits(stamp_t)-1:0]));
            if (m_tvalid && m_tready)
                sb.check_seconds(m_tdata[EPOCH_W-1:0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic stamp_t make_stamp(int y, int mo, int d, int h, int mi, int s,
                                          bit neg, int oh, int om);
        stamp_t st;
        st.year            = YEAR_W'(y);
        st.month           = MONTH_W'(mo);
        st.day             = DAY_W'(d);
        st.hour            = HOUR_W'(h);
        st.minute          = MINUTE_W'(mi);
        st.second          = SECOND_W'(s);
        st.offset_negative = neg;
        st.offset_hours    = OFFH_W'(oh);
        st.offset_minutes  = OFFM_W'(om);
        return st;
    endfunction

    // Mostly calendar-valid timestamps, the rest with every field bit random
    function automatic stamp_t random_stamp();
        if ($urandom_range(0, 3) != 0)
            return make_stamp($urandom_range(0, 9999), $urandom_range(1, 12),
                              $urandom_range(1, 31), $urandom_range(0, 23),
                              $urandom_range(0, 59), $urandom_range(0, 60),
                              1'($urandom_range(0, 1)), $urandom_range(0, 23),
                              $urandom_range(0, 59));
        else
            return stamp_t'($bits(stamp_t)'({$urandom, $urandom}));
    endfunction

    task automatic send_stamp(input stamp_t st);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(56 - $bits(stamp_t)){1'b0}}, st};
        do @(posedge aclk); while (!s_tready);
    endtask

    // One edge first, so the monitor has noted the last accepted transaction
    task automatic wait_drained();
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Result side: random stall before each transaction, none while sink_steady
    task automatic run_sink();
        int stall;
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            run_sink();
        join_none

        // Directed: epoch, edges of the nominal range, leap rules, carries
        send_stamp(make_stamp(1970, 1, 1, 0, 0, 0, 1'b0, 0, 0));
        send_stamp(make_stamp(1969, 12, 31, 23, 59, 59, 1'b0, 0, 0));
        send_stamp(make_stamp(2000, 2, 29, 12, 0, 0, 1'b0, 5, 30));
        send_stamp(make_stamp(1900, 3, 1, 0, 0, 0, 1'b1, 3, 0));
        send_stamp(make_stamp(0, 1, 1, 0, 0, 0, 1'b0, 23, 59));
        send_stamp(make_stamp(0, 0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_stamp(make_stamp(9999, 12, 31, 23, 59, 60, 1'b1, 23, 59));
        send_stamp(make_stamp(16383, 15, 31, 31, 63, 63, 1'b1, 31, 63));
        send_stamp(make_stamp(10700, 1, 1, 0, 0, 0, 1'b0, 31, 63));
        // every month code including zero and the ones past December
        for (int mo = 0; mo < 16; mo++)
            send_stamp(make_stamp(2023, mo, 15, 6, 30, 0, mo[0], mo, 15));
        s_tvalid <= 1'b0;
        wait_drained();

        // Random phases, each with its own idling pattern
        for (int i = 0; i < RANDOM_STAMPS; i++) begin
            if (i % PHASE_LEN == 0) begin
                src_steady  = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_STAMPS / 2) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            send_stamp(random_stamp());
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
